// ===== rtl/srtf_pkg.sv =====
// ----------------------------------------------------------------------------
// srtf_pkg
// Types, constants and helpers shared by the shortest-remaining-time scheduler.
// ----------------------------------------------------------------------------
package srtf_pkg;

	localparam int JOB_SLOTS = 16;
	localparam int TIME_BITS = 16;
	localparam int SLOT_BITS = $clog2(JOB_SLOTS);
	localparam int CNT_BITS  = $clog2(JOB_SLOTS + 1);

	typedef logic [TIME_BITS-1:0] time_t;
	typedef logic [SLOT_BITS-1:0] slot_t;
	typedef logic [CNT_BITS-1:0]  cnt_t;

	localparam time_t TIME_MAX  = '1;
	localparam cnt_t  SLOTS_CNT = cnt_t'(JOB_SLOTS);

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_TICK  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STS_OK    = 2'd0,
		STS_FULL  = 2'd1,
		STS_ZERO  = 2'd2,
		STS_SPARE = 2'd3
	} status_code_t;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_DRAIN  = 4'b0100,
		S_UPDATE = 4'b1000
	} fsm_t;

	typedef struct packed {
		time_t arrival;
		time_t burst;
		time_t remaining;
		logic  done;
	} job_t;

	typedef struct packed {
		logic  wr_en;
		slot_t wr_addr;
		job_t  wr_data;
		logic  rd_en;
		slot_t rd_addr;
	} mem_req_t;

	function automatic time_t sat_inc(input time_t v);
		sat_inc = (v == TIME_MAX) ? TIME_MAX : time_t'(v + time_t'(1));
	endfunction

endpackage

// ===== rtl/srtf_job_mem.sv =====
// ----------------------------------------------------------------------------
// srtf_job_mem
// Job table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module srtf_job_mem
	import srtf_pkg::*;
(
	input  logic     clk,
	input  mem_req_t req,
	output job_t     rdata
);

	job_t mem [JOB_SLOTS];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rdata <= mem[req.rd_addr];
		end
	end

endmodule

// ===== rtl/shortest_remaining_time_scheduler.sv =====
// ----------------------------------------------------------------------------
// shortest_remaining_time_scheduler
// Preemptive SRTF scheduler over a table of job slots held in one memory.
// ----------------------------------------------------------------------------
// Load, clear and unused items complete in the cycle they are accepted. A tick
// reads the job table one slot per cycle through the single memory read port,
// passing from the accept through the scan, a drain state for the registered
// read, and an update state that writes the chosen job back and registers the
// result. A tick on an empty table completes at once. The table needs no
// clearing after reset; only slots below the fill count are read.
// While a result waits in the output register a tick may still be accepted
// and scanned; its result is held back until the output register is free.
module shortest_remaining_time_scheduler
	import srtf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  operation,
	input  logic [15:0] arrival_time,
	input  logic [15:0] burst_time,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [1:0]  status,
	output logic        ran_valid,
	output logic [3:0]  ran_slot,
	output logic        job_finished,
	output logic [15:0] finish_time,
	output logic [15:0] turnaround_time,
	output logic [15:0] waiting_time,
	output logic [15:0] now_time,
	output logic [15:0] idle_ticks
);

	fsm_t     state_q;
	cnt_t     loaded_q;
	time_t    clock_q;
	time_t    idle_q;
	slot_t    scan_q;
	logic     rd_vld_s1;
	slot_t    rd_slot_s1;
	logic     found_q;
	slot_t    best_slot_q;
	job_t     best_q;
	job_t     rdata;
	mem_req_t mem_req;

	logic         rsp_valid_q;
	status_code_t status_q;
	logic         ran_valid_q;
	slot_t        ran_slot_q;
	logic         finished_q;
	time_t        finish_q;
	time_t        tat_q;
	time_t        wait_q;
	time_t        now_q;
	time_t        idle_out_q;

	op_t   op;
	logic  tick_scan;
	logic  out_free;
	logic  accept;
	logic  load_ok;
	logic  scan_last;
	logic  better;
	logic  upd_fire;
	logic  rsp_load;
	time_t clk_new;
	time_t idle_new;
	time_t rem_new;
	logic  fin_new;
	time_t tat_new;
	time_t wait_new;

	srtf_job_mem u_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (rdata)
	);

	always_comb begin
		op        = op_t'(operation);
		tick_scan = (op == OP_TICK) && (loaded_q != '0);
		out_free  = !rsp_valid_q || !rsp_stall;
		req_stall = (state_q != S_IDLE) || (!out_free && !tick_scan);
		accept    = req_valid && !req_stall;
		load_ok   = (op == OP_LOAD) && (burst_time != '0) && (loaded_q < SLOTS_CNT);
		scan_last = (cnt_t'(scan_q) + cnt_t'(1)) == loaded_q;
		better    = rd_vld_s1 && !rdata.done && (rdata.arrival <= clock_q) &&
			(!found_q || (rdata.remaining < best_q.remaining));
		upd_fire  = (state_q == S_UPDATE) && out_free;
		rsp_load  = (accept && !tick_scan) || upd_fire;

		clk_new  = sat_inc(clock_q);
		idle_new = sat_inc(idle_q);
		rem_new  = (best_q.remaining != '0) ? time_t'(best_q.remaining - time_t'(1)) : '0;
		fin_new  = (rem_new == '0);
		tat_new  = (clk_new >= best_q.arrival) ? time_t'(clk_new - best_q.arrival) : '0;
		wait_new = (tat_new >= best_q.burst) ? time_t'(tat_new - best_q.burst) : '0;

		mem_req.rd_en = (state_q == S_SCAN);
		mem_req.rd_addr = scan_q;
		if (state_q == S_UPDATE) begin
			mem_req.wr_en   = upd_fire && found_q;
			mem_req.wr_addr = best_slot_q;
			mem_req.wr_data = '{arrival: best_q.arrival, burst: best_q.burst,
				remaining: rem_new, done: fin_new};
		end else begin
			mem_req.wr_en   = accept && load_ok;
			mem_req.wr_addr = loaded_q[SLOT_BITS-1:0];
			mem_req.wr_data = '{arrival: arrival_time, burst: burst_time,
				remaining: burst_time, done: 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			loaded_q  <= '0;
			clock_q   <= '0;
			idle_q    <= '0;
			rd_vld_s1 <= 1'b0;
			found_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == S_SCAN);
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (better) begin
				found_q <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (tick_scan) begin
							found_q <= 1'b0;
							state_q <= S_SCAN;
						end else begin
							case (op)
								OP_LOAD: begin
									if (load_ok) begin
										loaded_q <= cnt_t'(loaded_q + cnt_t'(1));
									end
								end
								OP_TICK: begin
									clock_q <= clk_new;
									idle_q  <= idle_new;
								end
								OP_CLEAR: begin
									loaded_q <= '0;
									clock_q  <= '0;
									idle_q   <= '0;
								end
								default: begin
								end
							endcase
						end
					end
				end
				S_SCAN: begin
					if (scan_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					if (upd_fire) begin
						clock_q     <= clk_new;
						if (!found_q) begin
							idle_q <= idle_new;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// scan datapath
	always_ff @(posedge clk) begin
		rd_slot_s1 <= scan_q;
		if (state_q == S_SCAN) begin
			scan_q <= slot_t'(scan_q + slot_t'(1));
		end else begin
			scan_q <= '0;
		end
		if (better) begin
			best_q      <= rdata;
			best_slot_q <= rd_slot_s1;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (accept && !tick_scan) begin
			ran_valid_q <= 1'b0;
			finished_q  <= 1'b0;
			finish_q    <= '0;
			tat_q       <= '0;
			wait_q      <= '0;
			ran_slot_q  <= '0;
			status_q    <= STS_OK;
			now_q       <= clock_q;
			idle_out_q  <= idle_q;
			case (op)
				OP_LOAD: begin
					if (burst_time == '0) begin
						status_q <= STS_ZERO;
					end else if (!load_ok) begin
						status_q <= STS_FULL;
					end else begin
						ran_slot_q <= loaded_q[SLOT_BITS-1:0];
					end
				end
				OP_TICK: begin
					now_q      <= clk_new;
					idle_out_q <= idle_new;
				end
				OP_CLEAR: begin
					now_q      <= '0;
					idle_out_q <= '0;
				end
				default: begin
				end
			endcase
		end else if (upd_fire) begin
			status_q    <= STS_OK;
			now_q       <= clk_new;
			ran_valid_q <= found_q;
			ran_slot_q  <= found_q ? best_slot_q : '0;
			finished_q  <= found_q && fin_new;
			finish_q    <= (found_q && fin_new) ? clk_new : '0;
			tat_q       <= (found_q && fin_new) ? tat_new : '0;
			wait_q      <= (found_q && fin_new) ? wait_new : '0;
			idle_out_q  <= found_q ? idle_q : idle_new;
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign status          = status_q;
	assign ran_valid       = ran_valid_q;
	assign ran_slot        = ran_slot_q;
	assign job_finished    = finished_q;
	assign finish_time     = finish_q;
	assign turnaround_time = tat_q;
	assign waiting_time    = wait_q;
	assign now_time        = now_q;
	assign idle_ticks      = idle_out_q;

endmodule
